[rtl/md5h_pkg.sv]
// -----------------------------------------------------------------------------
// MD5 hasher package
// Shared types, constants and round tables for the MD5 message hasher.
// -----------------------------------------------------------------------------
package md5h_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  LENGTH_POS = 6'd56;
	localparam int          QDEPTH = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_number;
		logic        last_word;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_STORE, ST_ROUND, ST_ADD, ST_PAD, ST_ZERO, ST_LEN_LO, ST_LEN_HI,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
		32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
		32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
		32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
		32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
		32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
		return k[i];
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] i);
		logic [4:0] s [16];
		s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
			5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
		return s[{i[5:4], i[1:0]}];
	endfunction

	function automatic logic [3:0] round_g(input logic [5:0] i);
		logic [3:0] n;
		n = i[3:0];
		case (i[5:4])
			2'd0: return n;
			2'd1: return 4'(n * 4'd5 + 4'd1);
			2'd2: return 4'(n * 4'd3 + 4'd5);
			default: return 4'(n * 4'd7);
		endcase
	endfunction

endpackage

[rtl/md5h_stream_if.sv]
// -----------------------------------------------------------------------------
// MD5 hasher stream interface
// Valid/ready channel carrying one payload word.
// -----------------------------------------------------------------------------
interface md5h_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/md5h_ram.sv]
// -----------------------------------------------------------------------------
// MD5 hasher generic RAM
// Single write port, single registered read port.
// -----------------------------------------------------------------------------
module md5h_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/md5h_front.sv]
// -----------------------------------------------------------------------------
// MD5 hasher front end
// Accept words, drop idle ones, queue the rest for the core.
// -----------------------------------------------------------------------------
module md5h_front import md5h_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	md5h_stream_if.sink in_ch,
	input  logic     pop,
	output logic     q_valid,
	output in_word_t q_head
);
	in_word_t  buf_q [QDEPTH];
	logic      rd_q, wr_q;
	logic [1:0] cnt_q;
	logic      push, useful;

	assign in_ch.ready = cnt_q != 2'(QDEPTH);
	assign useful = in_ch.data.byte_present | in_ch.data.end_of_message;
	assign push = in_ch.valid & in_ch.ready & useful;
	assign q_valid = cnt_q != 2'd0;
	assign q_head = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

[rtl/md5h_core.sv]
// -----------------------------------------------------------------------------
// MD5 hasher core
// Pack bytes, pad, run 64 rounds one per cycle, emit the digest.
// -----------------------------------------------------------------------------
module md5h_core import md5h_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  in_word_t q_head,
	output logic     pop,
	md5h_stream_if.source out_ch
);
	state_t      state_q, state_d;
	logic [31:0] ca_q, cb_q, cc_q, cd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] count_q;
	logic [31:0] word_q;
	logic [5:0]  rnd_q;
	logic [4:0]  zw_q;
	logic        fin_q, second_q, pad_q;
	logic [1:0]  emit_q;
	in_word_t    cur_q;

	logic        we;
	logic [3:0]  waddr, raddr;
	logic [31:0] wdata, rdata;
	logic [31:0] f, sum, rot;
	logic [5:0]  pos;
	logic [1:0]  lane;
	logic [31:0] lane_word;
	logic [7:0]  lane_byte;
	logic [4:0]  zlim;

	md5h_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign pos = count_q[5:0];
	assign lane = pos[1:0];
	assign zlim = second_q ? 5'd16 : 5'd14;

	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + f + round_k(rnd_q) + rdata;
		rot = (sum << round_s(rnd_q)) | (sum >> (6'd32 - {1'b0, round_s(rnd_q)}));
	end

	always_comb begin
		lane_byte = cur_q.byte_present && state_q == ST_STORE ? cur_q.data_byte : PAD_BYTE;
		lane_word = lane == 2'd0 ? 32'd0 : word_q;
		lane_word[8*lane +: 8] = lane_byte;
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		we = 1'b0;
		waddr = pos[5:2];
		wdata = lane_word;
		raddr = round_g(rnd_q);
		out_ch.valid = 1'b0;
		out_ch.data.word_number = emit_q;
		out_ch.data.last_word = emit_q == 2'd3;
		case (emit_q)
			2'd0: out_ch.data.digest_word = ca_q;
			2'd1: out_ch.data.digest_word = cb_q;
			2'd2: out_ch.data.digest_word = cc_q;
			default: out_ch.data.digest_word = cd_q;
		endcase
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				if (cur_q.byte_present) begin
					we = 1'b1;
					if (pos == 6'd63) state_d = ST_ROUND;
					else if (cur_q.end_of_message) state_d = ST_PAD;
					else state_d = ST_IDLE;
				end else begin
					state_d = ST_PAD;
				end
				raddr = 4'd0;
			end
			ST_ROUND: begin
				raddr = round_g(rnd_q + 6'd1);
				if (rnd_q == 6'd63) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (!fin_q) state_d = ST_IDLE;
				else if (!pad_q) state_d = ST_PAD;
				else if (second_q) state_d = ST_ZERO;
				else state_d = ST_EMIT;
				raddr = 4'd0;
			end
			ST_PAD: begin
				we = 1'b1;
				state_d = ST_ZERO;
			end
			ST_ZERO: begin
				we = zw_q < zlim;
				waddr = zw_q[3:0];
				wdata = 32'd0;
				if (zw_q >= zlim) state_d = second_q ? ST_ROUND : ST_LEN_LO;
			end
			ST_LEN_LO: begin
				we = 1'b1;
				waddr = 4'd14;
				wdata = {count_q[28:0], 3'd0};
				state_d = ST_LEN_HI;
				raddr = 4'd0;
			end
			ST_LEN_HI: begin
				we = 1'b1;
				waddr = 4'd15;
				wdata = {29'd0, count_q[31:29]};
				state_d = ST_ROUND;
				raddr = 4'd0;
			end
			ST_EMIT: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready && emit_q == 2'd3) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ca_q <= INIT_A;
			cb_q <= INIT_B;
			cc_q <= INIT_C;
			cd_q <= INIT_D;
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			count_q <= '0;
			rnd_q <= '0;
			zw_q <= '0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			pad_q <= 1'b0;
			emit_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_STORE: begin
					if (cur_q.byte_present) count_q <= count_q + 32'd1;
					fin_q <= cur_q.end_of_message;
					second_q <= 1'b0;
					pad_q <= 1'b0;
					rnd_q <= '0;
					a_q <= ca_q;
					b_q <= cb_q;
					c_q <= cc_q;
					d_q <= cd_q;
				end
				ST_ROUND: begin
					a_q <= d_q;
					d_q <= c_q;
					c_q <= b_q;
					b_q <= b_q + rot;
					rnd_q <= rnd_q + 6'd1;
				end
				ST_ADD: begin
					ca_q <= ca_q + a_q;
					cb_q <= cb_q + b_q;
					cc_q <= cc_q + c_q;
					cd_q <= cd_q + d_q;
					a_q <= ca_q + a_q;
					b_q <= cb_q + b_q;
					c_q <= cc_q + c_q;
					d_q <= cd_q + d_q;
					if (fin_q && pad_q && second_q) begin
						second_q <= 1'b0;
						zw_q <= '0;
					end
				end
				ST_PAD: begin
					pad_q <= 1'b1;
					zw_q <= {1'b0, pos[5:2]} + 5'd1;
					second_q <= pos >= LENGTH_POS;
				end
				ST_ZERO: begin
					if (zw_q < zlim) zw_q <= zw_q + 5'd1;
					else if (second_q) begin
						zw_q <= '0;
						rnd_q <= '0;
					end
				end
				ST_LEN_HI: rnd_q <= '0;
				ST_EMIT: begin
					if (out_ch.ready) begin
						emit_q <= emit_q + 2'd1;
						if (emit_q == 2'd3) begin
							ca_q <= INIT_A;
							cb_q <= INIT_B;
							cc_q <= INIT_C;
							cd_q <= INIT_D;
							count_q <= '0;
							fin_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_head;
		if (state_q == ST_STORE && cur_q.byte_present) begin
			word_q <= lane_word;
		end else if (state_q == ST_PAD) begin
			word_q <= lane_word;
		end
	end
endmodule

[rtl/md5_message_hasher.sv]
// Each byte passes through the core's IDLE and STORE states; the byte that fills a
// block adds 64 rounds, one per cycle, reading the block RAM, then the chaining add.
// Finish: after the last word is stored, the core pads, runs one or two
// compressions and emits the four digest words.
// The front queue keeps taking bytes while the core is busy, until it is full.
// Reset: arst_n clears control and loads the MD5 start chaining values.
// -----------------------------------------------------------------------------
// MD5 message hasher
// Byte-serial MD5 digest: front queue plus round-serial compression core.
// -----------------------------------------------------------------------------
module md5_message_hasher import md5h_pkg::*; (
	input logic clk,
	input logic arst_n,
	md5h_stream_if.sink   in_ch,
	md5h_stream_if.source out_ch
);
	logic     q_valid, pop;
	in_word_t q_head;

	md5h_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .pop(pop), .q_valid(q_valid),
		.q_head(q_head)
	);

	md5h_core u_core (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head), .pop(pop),
		.out_ch(out_ch)
	);

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.last_word |-> out_ch.data.word_number == 2'd3)
		else $error("last word mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("digest word dropped");
endmodule
